### hdl/rgb_to_hsv_converter_unit_macros.svh
// Assertion macros of the RGB to HSV converter top level.
`ifndef RGB_TO_HSV_CONVERTER_UNIT_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RTHSV_CHECK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
    else $error("rthsv: invariant check failed");
`define RTHSV_CHECK_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error("rthsv: implication check failed");
`else
`define RTHSV_CHECK(lbl, prop)
`define RTHSV_CHECK_IMPL(lbl, ante, cons)
`endif
`endif

### hdl/rthsv_pkg.sv
// Shared constants and types of the RGB to HSV converter.
package rthsv_pkg;

    localparam int CH_W              = 8;
    localparam int HUE_W             = 15;
    localparam int SAT_W             = 17;
    localparam int SECT_W            = 11;
    localparam int HUE_SECTOR_DEG    = 60;
    localparam int HUE_FULL_DEG      = 360;
    localparam int HUE_FRAC_BITS_DEF = 6;
    localparam int SAT_FRAC_BITS_DEF = 16;

    // Front-end results: largest channel, spread and scaled sector position.
    typedef struct packed {
        logic [CH_W-1:0]   max_ch;
        logic [CH_W-1:0]   delta;
        logic [SECT_W-1:0] sect;
    } t_front;

    // Data that travels beside the dividers.
    typedef struct packed {
        logic [CH_W-1:0] max_ch;
        logic            hue_zero;
        logic            sat_zero;
    } t_side;

endpackage

### hdl/rgb_to_hsv_converter_unit.sv
// Top level of the pipelined RGB to HSV converter.
//
//  Channel   Direction  Handshake               Payload
//  pixel     in         start high, busy low    i_red, i_green, i_blue
//  result    out        o_result_valid strobe   o_hue, o_saturation, o_value
//
// One pixel enters every cycle; busy is always low because nothing stalls.
// Each result passes through one input register, one extrema stage, four
// divider stages and one output register.
// The reciprocal multiply and its correction set the divider depth.
// Reset clears only the valid bits; data registers are not reset.
`include "rgb_to_hsv_converter_unit_macros.svh"

module rgb_to_hsv_converter_unit #(
    parameter int HUE_FRAC_BITS = rthsv_pkg::HUE_FRAC_BITS_DEF,
    parameter int SAT_FRAC_BITS = rthsv_pkg::SAT_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rthsv_pkg::CH_W-1:0]    i_red,
    input  logic [rthsv_pkg::CH_W-1:0]    i_green,
    input  logic [rthsv_pkg::CH_W-1:0]    i_blue,
    output logic                          o_result_valid,
    output logic [rthsv_pkg::HUE_W-1:0]   o_hue,
    output logic [rthsv_pkg::SAT_W-1:0]   o_saturation,
    output logic [rthsv_pkg::CH_W-1:0]    o_value
);

    localparam int     LAT         = 7;
    localparam int     DIV_LAT     = 4;
    localparam int     SECT_MAX    = 6 * 255 - 1;
    localparam longint HUE_NUM_MAX = longint'(rthsv_pkg::HUE_SECTOR_DEG) * SECT_MAX
                                     * (64'd1 << HUE_FRAC_BITS) + 127;
    localparam int     HUE_NUM_W   = $clog2(HUE_NUM_MAX + 1);
    localparam longint HUE_FULL_L  = longint'(rthsv_pkg::HUE_FULL_DEG) << HUE_FRAC_BITS;
    localparam int     HUE_Q_W     = $clog2(HUE_FULL_L + 1);
    localparam longint SAT_NUM_MAX = (64'd255 << SAT_FRAC_BITS) + 127;
    localparam int     SAT_NUM_W   = $clog2(SAT_NUM_MAX + 1);
    localparam int     SAT_Q_W     = SAT_FRAC_BITS + 1;
    localparam logic [HUE_Q_W-1:0] HUE_FULL = HUE_Q_W'(HUE_FULL_L);
    localparam logic [SAT_Q_W-1:0] SAT_ONE  = SAT_Q_W'(64'd1 << SAT_FRAC_BITS);

    logic                       accept;
    logic [LAT-1:0]             r_vld;
    logic [rthsv_pkg::CH_W-1:0] r_red;
    logic [rthsv_pkg::CH_W-1:0] r_green;
    logic [rthsv_pkg::CH_W-1:0] r_blue;
    rthsv_pkg::t_front          front;
    rthsv_pkg::t_side           n_side;
    rthsv_pkg::t_side           r_side [DIV_LAT];
    logic [HUE_NUM_W-1:0]       hue_num;
    logic [SAT_NUM_W-1:0]       sat_num;
    logic [HUE_Q_W-1:0]         hue_q;
    logic [SAT_Q_W-1:0]         sat_q;
    logic [rthsv_pkg::HUE_W-1:0] n_hue;
    logic [rthsv_pkg::SAT_W-1:0] n_sat;
    logic [rthsv_pkg::HUE_W-1:0] r_hue;
    logic [rthsv_pkg::SAT_W-1:0] r_sat;
    logic [rthsv_pkg::CH_W-1:0]  r_value;

    // The pipeline advances every cycle, so a transaction is never refused.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_red   <= i_red;
        r_green <= i_green;
        r_blue  <= i_blue;
    end

    rthsv_extrema u_extrema (
        .i_clk   (i_clk),
        .i_red   (r_red),
        .i_green (r_green),
        .i_blue  (r_blue),
        .o_front (front)
    );

    // Adding half the divisor to each numerator rounds the quotient to nearest.
    assign hue_num = HUE_NUM_W'((HUE_NUM_W'(front.sect) * HUE_NUM_W'(rthsv_pkg::HUE_SECTOR_DEG))
                     << HUE_FRAC_BITS) + HUE_NUM_W'(front.delta >> 1);
    assign sat_num = (SAT_NUM_W'(front.delta) << SAT_FRAC_BITS) + SAT_NUM_W'(front.max_ch >> 1);

    rthsv_recip_div #(
        .NUM_W (HUE_NUM_W),
        .QUO_W (HUE_Q_W)
    ) u_hue_div (
        .i_clk (i_clk),
        .i_num (hue_num),
        .i_den (front.delta),
        .o_quo (hue_q)
    );

    rthsv_recip_div #(
        .NUM_W (SAT_NUM_W),
        .QUO_W (SAT_Q_W)
    ) u_sat_div (
        .i_clk (i_clk),
        .i_num (sat_num),
        .i_den (front.max_ch),
        .o_quo (sat_q)
    );

    always_comb begin
        n_side.max_ch   = front.max_ch;
        n_side.hue_zero = (front.delta == '0);
        n_side.sat_zero = (front.max_ch == '0);
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= n_side;
        for (int i = 1; i < DIV_LAT; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    // A grey pixel has hue zero, and a rounded hue of a full turn wraps to zero.
    always_comb begin
        if (r_side[DIV_LAT-1].hue_zero || (hue_q >= HUE_FULL)) begin
            n_hue = '0;
        end else begin
            n_hue = rthsv_pkg::HUE_W'(hue_q);
        end
        if (r_side[DIV_LAT-1].sat_zero) begin
            n_sat = '0;
        end else begin
            n_sat = rthsv_pkg::SAT_W'(sat_q);
        end
    end

    always_ff @(posedge i_clk) begin
        r_hue   <= n_hue;
        r_sat   <= n_sat;
        r_value <= r_side[DIV_LAT-1].max_ch;
    end

    assign o_result_valid = r_vld[LAT-1];
    assign o_hue          = r_hue;
    assign o_saturation   = r_sat;
    assign o_value        = r_value;

    `RTHSV_CHECK(a_fixed_latency, accept |-> ##7 o_result_valid)
    `RTHSV_CHECK_IMPL(a_hue_range, r_vld[LAT-2] && !r_side[DIV_LAT-1].hue_zero, hue_q <= HUE_FULL)
    `RTHSV_CHECK_IMPL(a_sat_range, r_vld[LAT-2] && !r_side[DIV_LAT-1].sat_zero, sat_q <= SAT_ONE)
    `RTHSV_CHECK_IMPL(a_black_pixel, o_result_valid && o_value == '0, o_saturation == '0 && o_hue == '0)

endmodule

### hdl/rthsv_extrema.sv
// Max, delta and hue sector position of one pixel, registered; min serves only to form delta.
module rthsv_extrema (
    input  logic                        i_clk,
    input  logic [rthsv_pkg::CH_W-1:0]  i_red,
    input  logic [rthsv_pkg::CH_W-1:0]  i_green,
    input  logic [rthsv_pkg::CH_W-1:0]  i_blue,
    output rthsv_pkg::t_front           o_front
);

    localparam int EXT_W = rthsv_pkg::SECT_W + 1;

    logic [rthsv_pkg::CH_W-1:0] max_ch;
    logic [rthsv_pkg::CH_W-1:0] min_ch;
    logic [rthsv_pkg::CH_W-1:0] delta;
    logic [EXT_W-1:0]           red_x;
    logic [EXT_W-1:0]           green_x;
    logic [EXT_W-1:0]           blue_x;
    logic [EXT_W-1:0]           delta_x;
    logic [EXT_W-1:0]           sect_x;
    rthsv_pkg::t_front          n_front;
    rthsv_pkg::t_front          r_front;

    always_comb begin
        max_ch = i_red;
        if (i_green > max_ch) max_ch = i_green;
        if (i_blue > max_ch) max_ch = i_blue;
        min_ch = i_red;
        if (i_green < min_ch) min_ch = i_green;
        if (i_blue < min_ch) min_ch = i_blue;
        delta = max_ch - min_ch;
    end

    assign red_x   = EXT_W'(i_red);
    assign green_x = EXT_W'(i_green);
    assign blue_x  = EXT_W'(i_blue);
    assign delta_x = EXT_W'(delta);

    // Red wins ties, then green. All sums are nonnegative modulo the width.
    always_comb begin
        if (max_ch == i_red) begin
            sect_x = green_x - blue_x;
            if (sect_x[EXT_W-1]) begin
                sect_x = sect_x + (delta_x << 2) + (delta_x << 1);
            end
        end else if (max_ch == i_green) begin
            sect_x = blue_x - red_x + (delta_x << 1);
        end else begin
            sect_x = red_x - green_x + (delta_x << 2);
        end
    end

    always_comb begin
        n_front.max_ch = max_ch;
        n_front.delta  = delta;
        n_front.sect   = sect_x[rthsv_pkg::SECT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_front <= n_front;
    end

    assign o_front = r_front;

endmodule

### hdl/rthsv_recip_div.sv
// Pipelined divider by an 8-bit divisor using a reciprocal table and one correction.
module rthsv_recip_div #(
    parameter int NUM_W = 24,
    parameter int QUO_W = 17
) (
    input  logic                        i_clk,
    input  logic [NUM_W-1:0]            i_num,
    input  logic [rthsv_pkg::CH_W-1:0]  i_den,
    output logic [QUO_W-1:0]            o_quo
);

    localparam int DEPTH  = 2 ** rthsv_pkg::CH_W;
    localparam int PROD_W = 2 * NUM_W;
    localparam int QD_W   = QUO_W + rthsv_pkg::CH_W;

    // Entry d >= 2 holds floor(2^NUM_W / d); entries 0 and 1 are zero, and a divisor of one bypasses the table.
    logic [NUM_W-1:0] recip_tab [DEPTH];

    assign recip_tab[0] = '0;
    assign recip_tab[1] = '0;
    for (genvar gi = 2; gi < DEPTH; gi++) begin : g_recip
        localparam logic [63:0] RECIP = (64'd1 << NUM_W) / gi;
        assign recip_tab[gi] = RECIP[NUM_W-1:0];
    end

    logic [NUM_W-1:0]           r_a_num;
    logic [rthsv_pkg::CH_W-1:0] r_a_den;
    logic [NUM_W-1:0]           r_a_recip;
    logic                       r_a_one;
    logic [NUM_W-1:0]           r_b_num;
    logic [rthsv_pkg::CH_W-1:0] r_b_den;
    logic [PROD_W-1:0]          r_b_prod;
    logic                       r_b_one;
    logic [NUM_W-1:0]           r_c_num;
    logic [rthsv_pkg::CH_W-1:0] r_c_den;
    logic [QUO_W-1:0]           r_c_q0;
    logic [NUM_W-1:0]           r_c_qd;
    logic [QUO_W-1:0]           r_d_quo;

    logic [PROD_W-1:0] n_b_prod;
    logic [QUO_W-1:0]  n_c_q0;
    logic [QD_W-1:0]   qd_full;
    logic [NUM_W-1:0]  n_c_qd;
    logic [NUM_W-1:0]  rem;
    logic [QUO_W-1:0]  n_d_quo;

    assign n_b_prod = PROD_W'(r_a_num) * PROD_W'(r_a_recip);

    // The estimate from the truncated reciprocal is the quotient or one below it.
    always_comb begin
        if (r_b_one) begin
            n_c_q0 = QUO_W'(r_b_num);
        end else begin
            n_c_q0 = QUO_W'(r_b_prod[PROD_W-1:NUM_W]);
        end
        qd_full = QD_W'(n_c_q0) * QD_W'(r_b_den);
        n_c_qd  = NUM_W'(qd_full);
    end

    always_comb begin
        rem     = r_c_num - r_c_qd;
        n_d_quo = r_c_q0 + QUO_W'(rem >= NUM_W'(r_c_den));
    end

    always_ff @(posedge i_clk) begin
        r_a_num   <= i_num;
        r_a_den   <= i_den;
        r_a_recip <= recip_tab[i_den];
        r_a_one   <= (i_den == rthsv_pkg::CH_W'(1));
        r_b_num   <= r_a_num;
        r_b_den   <= r_a_den;
        r_b_prod  <= n_b_prod;
        r_b_one   <= r_a_one;
        r_c_num   <= r_b_num;
        r_c_den   <= r_b_den;
        r_c_q0    <= n_c_q0;
        r_c_qd    <= n_c_qd;
        r_d_quo   <= n_d_quo;
    end

    assign o_quo = r_d_quo;

endmodule
